>>> sv/crsf_pkg.sv
// shared types, constants and the crc helper for the crsf frame resync deframer
// no dependencies; used by crsf_frame_resync_deframer_top
`default_nettype none

package crsf_pkg;

  // sizing
  localparam int MAX_PAYLOAD_LEN = 64;
  localparam int BUFFER_DEPTH    = 66;
  localparam int COUNTER_WIDTH   = 32;
  localparam int MAX_RESULTS     = 64;
  localparam int BYTE_W          = 8;

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
  localparam int LEN_W  = $clog2(MAX_PAYLOAD_LEN + 3);
  localparam int SUM_W  = ((ADDR_W > LEN_W) ? ADDR_W : LEN_W) + 1;
  localparam int NOUT_W = $clog2(MAX_RESULTS);
  localparam int TDATA_W = ((BYTE_W + 3 * COUNTER_WIDTH + 7) / 8) * 8;

  // protocol constants
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'hD5;
  localparam logic [BYTE_W-1:0] RC_TYPE  = 8'h16;
  localparam logic [BYTE_W-1:0] RC_ADDR_RESET = 8'd200;
  localparam int MIN_HELD = 4;
  localparam int MIN_LEN  = 2;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic [SUM_W-1:0]         sum_t;
  typedef logic [NOUT_W-1:0]        nout_t;
  typedef logic [BYTE_W-1:0]        byte_t;
  typedef logic [BYTE_W:0]          byte_ext_t;
  typedef logic [COUNTER_WIDTH-1:0] ctr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LEN,
    ST_CRC,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT,
    ST_STATUS_WAIT
  } state_t;

  // one byte of crc-8, msb first
  function automatic byte_t crc_byte(input byte_t crc_in, input byte_t data);
    byte_t c;
    c = crc_in ^ data;
    for (int b = 0; b < BYTE_W; b++) begin
      c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // circular buffer index, sum is below twice the depth
  function automatic addr_t wrap_idx(input sum_t s);
    sum_t r;
    r = (s >= sum_t'(BUFFER_DEPTH)) ? (s - sum_t'(BUFFER_DEPTH)) : s;
    return addr_t'(r);
  endfunction

endpackage

`default_nettype wire

>>> sv/crsf_frame_resync_deframer_top.sv
// crsf frame resync deframer: byte buffer, sequenced length check, crc-8 and frame output
// depends on crsf_pkg
`default_nettype none

// one input byte is taken only in idle; its work then runs on one crc/compare unit:
// each length byte looked at passes the scan and len states, a crc check reads one held
// byte a cycle, each emitted frame byte passes emit_rd, emit_ld and emit_wait plus output
// stall, and the status item waits out output stall; all is paced by the single buffer read port.
// reset (synchronous, active high) clears counters, fill count and head; address goes to 200.
// buffer contents are not cleared; only written entries are ever read.
module crsf_frame_resync_deframer_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration: rc_output_address
  input  wire logic                          cfg_we,
  input  wire logic [7:0]                    cfg_data,
  // input stream, tdata: data_byte[7:0]
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,
  // output stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // tdata: frame_byte[7:0], good_frame_total[39:8], bad_frame_total[71:40],
  //        forwarded_byte_total[103:72]
  output logic [crsf_pkg::TDATA_W-1:0]       m_tdata,
  // tuser: item_kind[0], frame_end[1]
  output logic [1:0]                         m_tuser,
  // tlast: run_last
  output logic                               m_tlast
);

  // held byte memory
  crsf_pkg::byte_t mem [crsf_pkg::BUFFER_DEPTH];
  crsf_pkg::byte_t rd_data;
  crsf_pkg::addr_t rd_addr;
  crsf_pkg::addr_t wr_addr;
  logic            wr_en;

  crsf_pkg::state_t state, state_next;
  crsf_pkg::addr_t  head, head_next;
  crsf_pkg::count_t count, count_next;
  crsf_pkg::len_t   ofs, ofs_next;
  crsf_pkg::len_t   len, len_next;
  crsf_pkg::byte_t  type_byte, type_byte_next;
  crsf_pkg::byte_t  crc, crc_next;
  crsf_pkg::nout_t  nout, nout_next;
  crsf_pkg::ctr_t   good, good_next;
  crsf_pkg::ctr_t   bad, bad_next;
  crsf_pkg::ctr_t   fwd, fwd_next;
  crsf_pkg::byte_t  rc_addr;

  logic             out_valid, out_valid_next;
  logic             out_kind, out_kind_next;
  crsf_pkg::byte_t  out_byte, out_byte_next;
  logic             out_end, out_end_next;
  logic             out_last, out_last_next;

  crsf_pkg::len_t    rd_ofs;
  crsf_pkg::len_t    flen;
  crsf_pkg::byte_ext_t need_len;
  logic              len_ok;
  logic              accept_in;

  assign accept_in = s_tvalid && s_tready;
  assign s_tready  = (state == crsf_pkg::ST_IDLE);
  assign flen      = len + crsf_pkg::len_t'(crsf_pkg::MIN_LEN);
  assign need_len  = {1'b0, rd_data} + crsf_pkg::byte_ext_t'(crsf_pkg::MIN_LEN);
  assign len_ok    = (rd_data >= crsf_pkg::byte_t'(crsf_pkg::MIN_LEN)) &&
                     (rd_data <= crsf_pkg::byte_t'(crsf_pkg::MAX_PAYLOAD_LEN));

  // read offset from the buffer head for each state
  always_comb begin
    case (state)
      crsf_pkg::ST_SCAN: rd_ofs = crsf_pkg::len_t'(1);
      crsf_pkg::ST_LEN:  rd_ofs = crsf_pkg::len_t'(2);
      crsf_pkg::ST_CRC:  rd_ofs = ofs + crsf_pkg::len_t'(1);
      default:           rd_ofs = ofs;
    endcase
  end

  assign rd_addr = crsf_pkg::wrap_idx(crsf_pkg::sum_t'(head) + crsf_pkg::sum_t'(rd_ofs));
  assign wr_addr = crsf_pkg::wrap_idx(crsf_pkg::sum_t'(head) + crsf_pkg::sum_t'(count));
  assign wr_en   = accept_in;

  // buffer write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= s_tdata;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer and datapath next values
  always_comb begin
    logic advance;
    state_next     = state;
    head_next      = head;
    count_next     = count;
    ofs_next       = ofs;
    len_next       = len;
    type_byte_next = type_byte;
    crc_next       = crc;
    nout_next      = nout;
    good_next      = good;
    bad_next       = bad;
    fwd_next       = fwd;
    out_valid_next = out_valid;
    out_kind_next  = out_kind;
    out_byte_next  = out_byte;
    out_end_next   = out_end;
    out_last_next  = out_last;
    advance        = 1'b0;

    case (state)
      crsf_pkg::ST_IDLE: begin
        if (accept_in) begin
          // full buffer drops its oldest byte, the new byte takes that slot
          if (count == crsf_pkg::count_t'(crsf_pkg::BUFFER_DEPTH)) begin
            head_next = crsf_pkg::wrap_idx(crsf_pkg::sum_t'(head) + crsf_pkg::sum_t'(1));
          end else begin
            count_next = count + crsf_pkg::count_t'(1);
          end
          nout_next  = '0;
          state_next = crsf_pkg::ST_SCAN;
        end
      end

      crsf_pkg::ST_SCAN: begin
        if (count < crsf_pkg::count_t'(crsf_pkg::MIN_HELD)) begin
          out_valid_next = 1'b1;
          out_kind_next  = 1'b1;
          out_byte_next  = '0;
          out_end_next   = 1'b0;
          out_last_next  = 1'b1;
          state_next     = crsf_pkg::ST_STATUS_WAIT;
        end else begin
          state_next = crsf_pkg::ST_LEN;
        end
      end

      crsf_pkg::ST_LEN: begin
        if (!len_ok) begin
          head_next  = crsf_pkg::wrap_idx(crsf_pkg::sum_t'(head) + crsf_pkg::sum_t'(1));
          count_next = count - crsf_pkg::count_t'(1);
          state_next = crsf_pkg::ST_SCAN;
        end else if (crsf_pkg::byte_ext_t'(count) < need_len) begin
          // frame not complete yet, end the run
          out_valid_next = 1'b1;
          out_kind_next  = 1'b1;
          out_byte_next  = '0;
          out_end_next   = 1'b0;
          out_last_next  = 1'b1;
          state_next     = crsf_pkg::ST_STATUS_WAIT;
        end else begin
          len_next   = crsf_pkg::len_t'(rd_data);
          ofs_next   = crsf_pkg::len_t'(2);
          crc_next   = '0;
          state_next = crsf_pkg::ST_CRC;
        end
      end

      crsf_pkg::ST_CRC: begin
        if (ofs == len + crsf_pkg::len_t'(1)) begin
          // rd_data is the check byte
          if (crc == rd_data) begin
            ofs_next   = '0;
            state_next = crsf_pkg::ST_EMIT_RD;
          end else begin
            bad_next   = bad + crsf_pkg::ctr_t'(1);
            head_next  = crsf_pkg::wrap_idx(crsf_pkg::sum_t'(head) + crsf_pkg::sum_t'(1));
            count_next = count - crsf_pkg::count_t'(1);
            state_next = crsf_pkg::ST_SCAN;
          end
        end else begin
          crc_next = crsf_pkg::crc_byte(crc, rd_data);
          if (ofs == crsf_pkg::len_t'(2)) begin
            type_byte_next = rd_data;
          end
          ofs_next = ofs + crsf_pkg::len_t'(1);
        end
      end

      crsf_pkg::ST_EMIT_RD: begin
        state_next = crsf_pkg::ST_EMIT_LD;
      end

      crsf_pkg::ST_EMIT_LD: begin
        if (nout < crsf_pkg::nout_t'(crsf_pkg::MAX_RESULTS - 1)) begin
          out_valid_next = 1'b1;
          out_kind_next  = 1'b0;
          out_byte_next  = ((ofs == '0) && (type_byte == crsf_pkg::RC_TYPE)) ? rc_addr
                                                                           : rd_data;
          out_end_next   = (ofs == len + crsf_pkg::len_t'(1));
          out_last_next  = 1'b0;
          nout_next      = nout + crsf_pkg::nout_t'(1);
          state_next     = crsf_pkg::ST_EMIT_WAIT;
        end else begin
          // result space used up, byte is consumed but not shown
          advance = 1'b1;
        end
      end

      crsf_pkg::ST_EMIT_WAIT: begin
        if (m_tready) begin
          out_valid_next = 1'b0;
          advance        = 1'b1;
        end
      end

      crsf_pkg::ST_STATUS_WAIT: begin
        if (m_tready) begin
          out_valid_next = 1'b0;
          state_next     = crsf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = crsf_pkg::ST_IDLE;
      end
    endcase

    // step to the next frame byte or retire the frame
    if (advance) begin
      if (ofs == len + crsf_pkg::len_t'(1)) begin
        good_next  = good + crsf_pkg::ctr_t'(1);
        fwd_next   = fwd + crsf_pkg::ctr_t'(flen);
        head_next  = crsf_pkg::wrap_idx(crsf_pkg::sum_t'(head) + crsf_pkg::sum_t'(flen));
        count_next = count - crsf_pkg::count_t'(flen);
        state_next = crsf_pkg::ST_SCAN;
      end else begin
        ofs_next   = ofs + crsf_pkg::len_t'(1);
        state_next = crsf_pkg::ST_EMIT_RD;
      end
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crsf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      nout      <= '0;
      good      <= '0;
      bad       <= '0;
      fwd       <= '0;
      out_valid <= 1'b0;
    end else begin
      head      <= head_next;
      count     <= count_next;
      nout      <= nout_next;
      good      <= good_next;
      bad       <= bad_next;
      fwd       <= fwd_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ofs       <= ofs_next;
    len       <= len_next;
    type_byte <= type_byte_next;
    crc       <= crc_next;
    out_kind  <= out_kind_next;
    out_byte  <= out_byte_next;
    out_end   <= out_end_next;
    out_last  <= out_last_next;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      rc_addr <= crsf_pkg::RC_ADDR_RESET;
    end else if (cfg_we) begin
      rc_addr <= cfg_data;
    end
  end

  // output packing, counters only in the status item
  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tuser  = {out_end, out_kind};
  assign m_tdata  = crsf_pkg::TDATA_W'({(out_kind ? fwd  : '0),
                                        (out_kind ? bad  : '0),
                                        (out_kind ? good : '0),
                                        out_byte});

endmodule

`default_nettype wire

>>> dv/crsf_deframe_checker.sv
// checker for the crsf frame resync deframer: watches config, input and output streams,
// keeps its own copy of the byte buffer and counters and compares every output transaction
// depends on crsf_pkg
module crsf_deframe_checker
  import crsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [7:0]         s_tdata,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [TDATA_W-1:0] m_tdata,
  input  logic [1:0]         m_tuser,
  input  logic               m_tlast,
  output int                 fail_count,
  output int                 pending,
  output int                 results_checked,
  output int                 frames_accepted,
  output int                 frames_cut,
  output int                 crc_failures
);
  timeunit 1ns;
  timeprecision 1ps;

  // one predicted output transaction
  typedef struct {
    bit    is_status;
    byte_t data;
    bit    frame_end;
    bit    run_end;
    ctr_t  good;
    ctr_t  bad;
    ctr_t  fwd;
  } out_item_t;

  out_item_t deframer_out_q[$];
  byte_t     held_model[$];
  ctr_t      good_ctr;
  ctr_t      bad_ctr;
  ctr_t      fwd_ctr;
  byte_t     rc_addr;
  int        mismatches;
  int        checked;
  int        cut;

  // crc-8 poly 0xd5 over held bytes, fed one bit at a time, msb first
  function automatic byte_t held_crc(input int first, input int count);
    byte_t c;
    bit    fb;
    c = '0;
    for (int i = first; i < first + count; i++) begin
      for (int b = BYTE_W - 1; b >= 0; b--) begin
        fb = c[BYTE_W-1] ^ held_model[i][b];
        c  = {c[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : byte_t'(0));
      end
    end
    return c;
  endfunction

  function automatic void push_item(input bit st, input byte_t d, input bit fe, input bit re,
                                    input ctr_t g, input ctr_t b, input ctr_t f);
    out_item_t it;
    it.is_status = st;
    it.data      = d;
    it.frame_end = fe;
    it.run_end   = re;
    it.good      = g;
    it.bad       = b;
    it.fwd       = f;
    deframer_out_q.push_back(it);
  endfunction

  // append one byte, rescan the buffer, queue frame bytes and the closing status
  task automatic deframe_byte(input byte_t din);
    int    room;
    int    flen;
    byte_t lenb;
    byte_t ob;
    room = MAX_RESULTS - 1;
    if (held_model.size() >= BUFFER_DEPTH) void'(held_model.pop_front());
    held_model.push_back(din);
    while (held_model.size() >= MIN_HELD) begin
      lenb = held_model[1];
      if (int'(lenb) < MIN_LEN || int'(lenb) > MAX_PAYLOAD_LEN) begin
        // length out of range: slip one byte
        void'(held_model.pop_front());
      end else begin
        flen = int'(lenb) + 2;
        if (held_model.size() < flen) break;
        if (held_crc(2, flen - 3) == held_model[flen - 1]) begin
          // good frame, bytes past the result limit are counted but not sent
          if (flen > room) cut++;
          for (int i = 0; i < flen; i++) begin
            ob = (i == 0 && held_model[2] == RC_TYPE) ? rc_addr : held_model[i];
            if (room > 0) begin
              push_item(1'b0, ob, i == flen - 1, 1'b0, '0, '0, '0);
              room--;
            end
          end
          good_ctr += 1;
          fwd_ctr  += ctr_t'(flen);
          repeat (flen) void'(held_model.pop_front());
        end else begin
          bad_ctr += 1;
          void'(held_model.pop_front());
        end
      end
    end
    push_item(1'b1, '0, 1'b0, 1'b1, good_ctr, bad_ctr, fwd_ctr);
  endtask

  function automatic int field_diff(input string fname, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  // compare one output transaction with the oldest prediction
  task automatic compare_out_item();
    out_item_t w;
    if (deframer_out_q.size() == 0) begin
      $error("output transaction with nothing predicted: tdata 0x%0h tuser %b tlast %b",
             m_tdata, m_tuser, m_tlast);
      mismatches++;
    end else begin
      w = deframer_out_q.pop_front();
      mismatches += field_diff("item_kind", 32'(w.is_status), 32'(m_tuser[0]));
      mismatches += field_diff("frame_byte", 32'(w.data), 32'(m_tdata[7:0]));
      mismatches += field_diff("frame_end", 32'(w.frame_end), 32'(m_tuser[1]));
      mismatches += field_diff("run_last", 32'(w.run_end), 32'(m_tlast));
      mismatches += field_diff("good_frame_total", w.good, m_tdata[39:8]);
      mismatches += field_diff("bad_frame_total", w.bad, m_tdata[71:40]);
      mismatches += field_diff("forwarded_byte_total", w.fwd, m_tdata[103:72]);
    end
  endtask

  // sample all channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      deframer_out_q.delete();
      held_model.delete();
      good_ctr   = '0;
      bad_ctr    = '0;
      fwd_ctr    = '0;
      rc_addr    = RC_ADDR_RESET;
      mismatches = 0;
      checked    = 0;
      cut        = 0;
    end else begin
      if (cfg_we) rc_addr = cfg_data;
      if (s_tvalid && s_tready) deframe_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        compare_out_item();
        checked++;
      end
    end
    fail_count      <= mismatches;
    pending         <= deframer_out_q.size();
    results_checked <= checked;
    frames_accepted <= int'(good_ctr);
    frames_cut      <= cut;
    crc_failures    <= int'(bad_ctr);
  end

endmodule

>>> dv/crsf_frame_resync_deframer_top_test.sv
// top of the crsf frame resync deframer regression: clock, reset, byte and frame stimulus,
// output back-pressure and the final verdict; checking is done in crsf_deframe_checker
// depends on crsf_pkg, crsf_frame_resync_deframer_top and crsf_deframe_checker
module crsf_frame_resync_deframer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import crsf_pkg::*;

  localparam int LONG_HOLD = 400;
  localparam int SETTLE    = 16;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               cfg_we   = 1'b0;
  logic [7:0]         cfg_data = 8'h00;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata  = 8'h00;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [1:0]         m_tuser;
  logic               m_tlast;

  int    fail_count;
  int    pending;
  int    results_checked;
  int    frames_accepted;
  int    frames_cut;
  int    crc_failures;
  int    sent_bytes   = 0;
  bit    tx_idle_on   = 1'b1;
  bit    rx_idle_on   = 1'b1;
  bit    hold_request = 1'b0;
  byte_t last_addr    = 8'h00;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  crsf_frame_resync_deframer_top uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  crsf_deframe_checker chk (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .m_tlast         (m_tlast),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .frames_accepted (frames_accepted),
    .frames_cut      (frames_cut),
    .crc_failures    (crc_failures)
  );

  // output back-pressure: random bursts, one long hold on request
  initial begin
    int rx_stall_left;
    rx_stall_left = 0;
    forever begin
      @(posedge clk);
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        m_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request  = 1'b0;
        rx_stall_left = LONG_HOLD - 1;
        m_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        rx_stall_left = $urandom_range(0, 10);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // run time limit
  initial begin
    #60_000_000;
    $display("crsf_frame_resync_deframer_top regression: fail");
    $finish;
  end

  // offer one byte, with an optional idle burst first
  task automatic send_byte(input byte_t b);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tdata  <= b;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_bytes++;
  endtask

  // build addr, len, type, payload, crc; send the first keep bytes of it
  task automatic send_frame(input byte_t addr, input int len, input byte_t ftype,
                            input bit corrupt, input int keep);
    byte_t fb[$];
    byte_t crc;
    fb.push_back(addr);
    fb.push_back(byte_t'(len));
    fb.push_back(ftype);
    for (int i = 0; i < len - 2; i++) fb.push_back(byte_t'($urandom_range(0, 255)));
    crc = 8'h00;
    for (int i = 2; i < fb.size(); i++) begin
      crc ^= fb[i];
      repeat (8) crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
    end
    if (corrupt) crc ^= byte_t'(1 << $urandom_range(0, 7));
    fb.push_back(crc);
    for (int i = 0; i < keep && i < fb.size(); i++) send_byte(fb[i]);
  endtask

  // mostly good frames with random content, plus bad crcs, noise and cut-off frames
  task automatic random_traffic(input int budget);
    int    start;
    int    pick;
    int    lsel;
    int    len;
    byte_t ftype;
    start = sent_bytes;
    while (sent_bytes - start < budget) begin
      pick = $urandom_range(0, 99);
      lsel = $urandom_range(0, 19);
      if (lsel < 16) len = $urandom_range(2, 10);
      else if (lsel < 19) len = $urandom_range(11, 40);
      else len = $urandom_range(41, MAX_PAYLOAD_LEN);
      ftype = $urandom_range(0, 1) ? RC_TYPE : byte_t'($urandom_range(0, 255));
      if (pick < 60) begin
        send_frame(byte_t'($urandom_range(0, 255)), len, ftype, 1'b0, len + 2);
      end else if (pick < 75) begin
        send_frame(byte_t'($urandom_range(0, 255)), len, ftype, 1'b1, len + 2);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 6)) send_byte(byte_t'($urandom_range(0, 255)));
      end else begin
        send_frame(byte_t'($urandom_range(0, 255)), len, ftype, 1'b0,
                   $urandom_range(1, len + 1));
      end
    end
  endtask

  // stop offering and wait until every predicted transaction has come out
  task automatic wait_drained(input int settle);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_rc_addr(input byte_t v);
    cfg_data <= v;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // noise with lengths 255, 1, 65 and 0 at offset one
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h41);
    send_byte(8'h00);
    // shortest frames: rc type gets the reset address, other type keeps its own
    send_frame(8'hFF, MIN_LEN, RC_TYPE, 1'b0, MIN_LEN + 2);
    send_frame(8'h00, MIN_LEN, 8'h28, 1'b0, MIN_LEN + 2);
    // crc failure then rescan, then a good frame with type 0xff
    send_frame(8'hEE, 3, RC_TYPE, 1'b1, 5);
    send_frame(8'hC8, 5, 8'hFF, 1'b0, 7);

    // phase a: address 0xff, longest frame cut at the result limit, long receiver hold
    wait_drained(4);
    write_rc_addr(8'hFF);
    send_frame(byte_t'($urandom_range(0, 255)), MAX_PAYLOAD_LEN, RC_TYPE, 1'b0,
               MAX_PAYLOAD_LEN + 2);
    hold_request = 1'b1;
    random_traffic(12);

    // phase b: address 0x00
    wait_drained(4);
    write_rc_addr(8'h00);
    random_traffic(12);

    // phase c: random address, no idling on either side
    wait_drained(4);
    last_addr = byte_t'($urandom_range(1, 254));
    write_rc_addr(last_addr);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_traffic(12);

    wait_drained(SETTLE);
    $display("covered %0d input bytes, %0d output transactions: %0d frames accepted",
             sent_bytes, results_checked, frames_accepted);
    $display("%0d frames cut at the result limit, %0d crc failures, rc address 200/ff/00/%02h",
             frames_cut, crc_failures, last_addr);
    if (fail_count == 0) begin
      $display("crsf_frame_resync_deframer_top regression: pass");
    end else begin
      $display("crsf_frame_resync_deframer_top regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/crsf_pkg.sv
sv/crsf_frame_resync_deframer_top.sv
dv/crsf_deframe_checker.sv
dv/crsf_frame_resync_deframer_top_test.sv
